// ----- sv/tse_pkg.sv -----
// ----------------------------------------------------------------------------
// Tagged string extractor package
// Shared types and constants for the tagged string extractor: the marker
// register set, register indexes, result status codes and scan phases.
// ----------------------------------------------------------------------------
package tse_pkg;

	// Marker registers as seen by the scanning logic.
	typedef struct packed {
		logic [7:0] first_marker;
		logic [7:0] second_marker;
	} tse_cfg_t;

	// Register indexes, taken from the word address.
	localparam logic REG_FIRST_MARKER  = 1'b0;
	localparam logic REG_SECOND_MARKER = 1'b1;

	// Reset values of the marker registers.
	localparam logic [7:0] FIRST_MARKER_RST  = 8'h80;
	localparam logic [7:0] SECOND_MARKER_RST = 8'h1A;

	// Reset value of the previous byte: ASCII zero.
	localparam logic [7:0] PREV_BYTE_RST = 8'h30;

	// Length byte codes.
	localparam logic [7:0] LEN_LONG_ONE = 8'h81;
	localparam logic [7:0] LEN_LONG_TWO = 8'h82;

	// Status of a result item.
	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_ERROR = 2'd2
	} tse_status_t;

	// Scan phases, one-hot.
	typedef enum logic [3:0] {
		PH_SCAN    = 4'b0001,
		PH_LEN     = 4'b0010,
		PH_LONGLEN = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} tse_phase_t;

endpackage

// ----- sv/tse_cfg.sv -----
// ----------------------------------------------------------------------------
// Tagged string extractor register file
// APB-style register port holding the two marker bytes, with read-back.
// ----------------------------------------------------------------------------
module tse_cfg
	import tse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output tse_cfg_t    cfg
);

	logic     wr_en;
	logic     reg_idx;
	tse_cfg_t cfg_q;

	// The port never inserts wait states.
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[2];

	// Marker registers, written in the access cycle of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_marker  <= FIRST_MARKER_RST;
			cfg_q.second_marker <= SECOND_MARKER_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FIRST_MARKER:  cfg_q.first_marker  <= pwdata[7:0];
				REG_SECOND_MARKER: cfg_q.second_marker <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read-back of the addressed register.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_FIRST_MARKER:  prdata[7:0] = cfg_q.first_marker;
			REG_SECOND_MARKER: prdata[7:0] = cfg_q.second_marker;
			default: ;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/tagged_string_extractor.sv -----
// ----------------------------------------------------------------------------
// Tagged string extractor
// Scans a byte stream for a two-byte marker, decodes the BER-style length
// that follows and passes out the payload bytes with a last flag, or an empty or error item.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Payload
//  in       sink       in_valid/in_stall   data_byte
//  out      source     out_valid/out_stall payload_byte, last_flag, status
//  cfg      sink       psel/penable/pready paddr, pwdata, prdata
//
// An item is taken into the input register, decoded against the scan state
// combinationally and its result, if any, lands in the output register, so
// an item can be accepted in every cycle while the output is not stalled and
// its result is offered from the output register. While a result waits, the
// input register can still take one item; a stall on the output then holds
// the input register and stalls the input in turn.
// Reset clears the scan state and both registers to empty; no clearing pass.
//
module tagged_string_extractor
	import tse_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic        last_flag,
	output logic [1:0]  status,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LEN_W = 8 * MAX_LENGTH_BYTES;
	localparam int LBL_W = $clog2(MAX_LENGTH_BYTES + 1);

	tse_cfg_t cfg;

	// Input register.
	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             advance;

	// Scan state.
	tse_phase_t       phase_q, phase_d;
	logic [7:0]       prev_q, prev_d;
	logic [LEN_W-1:0] rem_q, rem_d;
	logic [LBL_W-1:0] lbl_q, lbl_d;

	// Decode results.
	logic [LEN_W+7:0] rem_shift_full;
	logic [LEN_W-1:0] rem_shift;
	logic [LEN_W-1:0] rem_dec;
	logic [LBL_W-1:0] lbl_dec;
	logic             emit_c;
	logic [7:0]       res_byte_c;
	logic             res_last_c;
	tse_status_t      res_status_c;

	// Output register.
	logic             out_valid_q;
	logic [7:0]       res_byte_q;
	logic             res_last_q;
	tse_status_t      res_status_q;

	tse_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The held item moves on when the output register is free or being emptied.
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
		end
	end

	// Helpers for the long-form length and the payload count.
	assign rem_shift_full = {rem_q, data_s1};
	assign rem_shift      = rem_shift_full[LEN_W-1:0];
	assign rem_dec        = LEN_W'(rem_q - 1'b1);
	assign lbl_dec        = LBL_W'(lbl_q - 1'b1);

	// One step of the scanner for the held item.
	always_comb begin
		phase_d      = phase_q;
		prev_d       = prev_q;
		rem_d        = rem_q;
		lbl_d        = lbl_q;
		emit_c       = 1'b0;
		res_byte_c   = '0;
		res_last_c   = 1'b0;
		res_status_c = ST_DATA;
		unique case (phase_q)
			PH_SCAN: begin
				if (prev_q == cfg.first_marker && data_s1 == cfg.second_marker) begin
					phase_d = PH_LEN;
				end else begin
					prev_d = data_s1;
				end
			end
			PH_LEN: begin
				if (!data_s1[7]) begin
					// Short form.
					rem_d = LEN_W'(data_s1[6:0]);
					if (data_s1[6:0] == 7'd0) begin
						phase_d      = PH_SCAN;
						emit_c       = 1'b1;
						res_last_c   = 1'b1;
						res_status_c = ST_EMPTY;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else if (data_s1 == LEN_LONG_ONE ||
				             (data_s1 == LEN_LONG_TWO && MAX_LENGTH_BYTES >= 2)) begin
					// Long form: one or two length bytes follow.
					lbl_d   = LBL_W'(data_s1[1:0]);
					rem_d   = '0;
					phase_d = PH_LONGLEN;
				end else begin
					// Indefinite or unsupported length form.
					phase_d      = PH_SCAN;
					emit_c       = 1'b1;
					res_last_c   = 1'b1;
					res_status_c = ST_ERROR;
				end
			end
			PH_LONGLEN: begin
				rem_d = rem_shift;
				lbl_d = lbl_dec;
				if (lbl_dec == '0) begin
					if (rem_shift == '0) begin
						phase_d      = PH_SCAN;
						emit_c       = 1'b1;
						res_last_c   = 1'b1;
						res_status_c = ST_EMPTY;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				rem_d        = rem_dec;
				emit_c       = 1'b1;
				res_byte_c   = data_s1;
				res_status_c = ST_DATA;
				if (rem_dec == '0) begin
					phase_d    = PH_SCAN;
					res_last_c = 1'b1;
				end
			end
			default: begin
				phase_d = PH_SCAN;
			end
		endcase
	end

	// Scan state advances with each item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			prev_q  <= PREV_BYTE_RST;
			rem_q   <= '0;
			lbl_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			prev_q  <= prev_d;
			rem_q   <= rem_d;
			lbl_q   <= lbl_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit_c;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_c) begin
			res_byte_q   <= res_byte_c;
			res_last_q   <= res_last_c;
			res_status_q <= res_status_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = res_byte_q;
	assign last_flag    = res_last_q;
	assign status       = res_status_q;

`ifndef SYNTHESIS
	// A string in its payload always has bytes left to send.
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with zero bytes remaining");

	// The long-form phase always has length bytes still to read.
	a_longlen_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LONGLEN |-> lbl_q != '0)
		else $error("long-form phase with no length bytes left");

	// Empty and error results always close the string.
	a_close_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_status_q != ST_DATA |-> res_last_q)
		else $error("empty or error result without last flag");

	// The scan state only moves when an item passes the decode stage.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(rem_q) && $stable(prev_q))
		else $error("scan state changed without an item");

	// A blocked item stays in the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_s1))
		else $error("held item lost from input register");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged string extractor testbench
// Drives a byte stream into the extractor and checks every result item
// against a predictor of the marker scan and BER length decoding. A directed
// opening covers the length forms; framed random traffic under several
// marker settings and idling patterns follows.
// ----------------------------------------------------------------------------
module tb_top;
	import tse_pkg::*;

	localparam int MAX_LEN_BYTES = 2;
	localparam int WATCHDOG_LIMIT = 5000;

	// One expected result item.
	typedef struct {
		logic [7:0]  payload;
		logic        last;
		tse_status_t stat;
	} string_out_t;

	// Predicts the extractor and checks its result items in order.
	class extract_scoreboard;
		logic [7:0]  first_mark;
		logic [7:0]  second_mark;
		logic [7:0]  prev_byte;
		tse_phase_t  ph;
		logic [15:0] remaining;
		logic [1:0]  len_left;
		string_out_t expected_out[$];
		int          errors;

		function new();
			first_mark  = FIRST_MARKER_RST;
			second_mark = SECOND_MARKER_RST;
			prev_byte   = PREV_BYTE_RST;
			ph          = PH_SCAN;
			remaining   = '0;
			len_left    = '0;
			errors      = 0;
		endfunction

		function void set_marker(logic idx, logic [7:0] val);
			if (idx == REG_FIRST_MARKER)
				first_mark = val;
			else
				second_mark = val;
		endfunction

		function void push_out(logic [7:0] b, logic l, tse_status_t s);
			string_out_t e;
			e.payload = b;
			e.last    = l;
			e.stat    = s;
			expected_out.push_back(e);
		endfunction

		// The length is complete: either an empty string or the payload begins.
		function void length_known();
			if (remaining == 16'd0) begin
				ph = PH_SCAN;
				push_out(8'd0, 1'b1, ST_EMPTY);
			end else begin
				ph = PH_PAYLOAD;
			end
		endfunction

		// Advance the prediction by one accepted input item.
		function void take_byte(logic [7:0] b);
			case (ph)
				PH_LEN: begin
					if (b <= 8'd127) begin
						remaining = {8'd0, b};
						length_known();
					end else if (b == LEN_LONG_ONE ||
							(b == LEN_LONG_TWO && MAX_LEN_BYTES >= 2)) begin
						len_left  = b[1:0];
						remaining = '0;
						ph        = PH_LONGLEN;
					end else begin
						ph = PH_SCAN;
						push_out(8'd0, 1'b1, ST_ERROR);
					end
				end
				PH_LONGLEN: begin
					remaining = {remaining[7:0], b};
					len_left  = len_left - 2'd1;
					if (len_left == 2'd0)
						length_known();
				end
				PH_PAYLOAD: begin
					remaining = remaining - 16'd1;
					if (remaining == 16'd0) begin
						ph = PH_SCAN;
						push_out(b, 1'b1, ST_DATA);
					end else begin
						push_out(b, 1'b0, ST_DATA);
					end
				end
				default: begin
					// The previous byte is kept when the marker pair completes.
					ph = PH_SCAN;
					if (prev_byte == first_mark && b == second_mark)
						ph = PH_LEN;
					else
						prev_byte = b;
				end
			endcase
		endfunction

		// Compare one accepted result item with the oldest expectation.
		function void check_output(logic [7:0] b, logic l, logic [1:0] s);
			string_out_t e;
			if (expected_out.size() == 0) begin
				if (errors < 10)
					$display("unexpected result: payload %h last %b status %0d", b, l, s);
				errors++;
				return;
			end
			e = expected_out.pop_front();
			if (b !== e.payload || l !== e.last || s !== e.stat) begin
				if (errors < 10)
					$display("mismatch: expected payload %h last %b status %0d, got %h %b %0d",
						e.payload, e.last, e.stat, b, l, s);
				errors++;
			end
		endfunction

		function int pending();
			return expected_out.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  payload_byte;
	logic        last_flag;
	logic [1:0]  status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	extract_scoreboard sb;
	int                send_idle_pct;
	int                stall_pct;
	int                sent_count;
	int                quiet_cycles;

	tagged_string_extractor #(
		.MAX_LENGTH_BYTES(MAX_LEN_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.last_flag(last_flag),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver stalls at random.
	always @(posedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	// Monitors of both channels.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.take_byte(data_byte);
		if (arst_n && out_valid && !out_stall)
			sb.check_output(payload_byte, last_flag, status);
	end

	// Watchdog on cycles with no accepted item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("tagged_string_extractor test failed");
			$finish;
		end
	end

	// Offer one input item and wait until it is taken. The stall is looked at
	// mid-cycle, where it already holds the value seen by the next edge.
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		sent_count++;
	endtask

	// Wait until every expected item has come and the block has gone quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic write_marker(logic idx, logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_marker(idx, val);
	endtask

	// One framed string: marker pair, a length in some form and its payload.
	task automatic send_frame();
		int          form;
		int          k;
		logic [15:0] n;
		send_byte(sb.first_mark);
		send_byte(sb.second_mark);
		form = $urandom_range(99);
		n    = '0;
		if (form < 45) begin
			n = ($urandom_range(9) == 0) ? 16'($urandom_range(127)) : 16'($urandom_range(12));
			send_byte(n[7:0]);
		end else if (form < 65) begin
			n = ($urandom_range(9) == 0) ? 16'($urandom_range(255)) : 16'($urandom_range(16));
			send_byte(LEN_LONG_ONE);
			send_byte(n[7:0]);
		end else if (form < 85) begin
			n = ($urandom_range(14) == 0) ? 16'($urandom_range(300, 200))
				: 16'($urandom_range(16));
			send_byte(LEN_LONG_TWO);
			send_byte(n[15:8]);
			send_byte(n[7:0]);
		end else begin
			// Indefinite or over-long length form.
			if ($urandom_range(1) == 0)
				send_byte(8'h80);
			else
				send_byte(8'($urandom_range(255, 131)));
		end
		for (k = 0; k < n; k++)
			send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		int s;
		int m;
		int start;
		int k;
		logic [7:0] fm;
		logic [7:0] sm;

		sb            = new();
		send_idle_pct = 0;
		stall_pct     = 0;
		sent_count    = 0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		data_byte     <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening with the reset markers.
		// Empty string, then a string opened at once by the kept first marker.
		send_byte(8'h80); send_byte(8'h1A); send_byte(8'h00);
		send_byte(8'h1A); send_byte(8'h01); send_byte(8'hFF);
		// Indefinite length.
		send_byte(8'h1A); send_byte(8'h80);
		// Long form of zero.
		send_byte(8'h1A); send_byte(LEN_LONG_ONE); send_byte(8'h00);
		// Non-minimal two-byte length.
		send_byte(8'h1A); send_byte(LEN_LONG_TWO); send_byte(8'h00); send_byte(8'h02);
		send_byte(8'h00); send_byte(8'hFF);
		// Unsupported long forms.
		send_byte(8'h1A); send_byte(8'h83);
		send_byte(8'h1A); send_byte(8'hFF);
		// Short form at its top, with its full payload.
		send_byte(8'h1A); send_byte(8'h7F);
		for (k = 0; k < 127; k++)
			send_byte(8'(k * 2 + 1));
		drain();

		// Random traffic under several marker settings and idling patterns.
		for (s = 0; s < 5; s++) begin
			case (s)
				0: begin fm = FIRST_MARKER_RST; sm = SECOND_MARKER_RST; end
				1: begin fm = 8'h00; sm = 8'h00; end
				2: begin fm = 8'hFF; sm = 8'hFF; end
				3: begin fm = 8'hFF; sm = 8'h00; end
				default: begin fm = 8'($urandom()); sm = 8'($urandom()); end
			endcase
			write_marker(REG_FIRST_MARKER, fm);
			write_marker(REG_SECOND_MARKER, sm);
			for (m = 0; m < 4; m++) begin
				case (m)
					0: begin send_idle_pct = 0;  stall_pct = 0;  end
					1: begin send_idle_pct = 65; stall_pct = 0;  end
					2: begin send_idle_pct = 0;  stall_pct = 65; end
					default: begin send_idle_pct = 38; stall_pct = 38; end
				endcase
				start = sent_count;
				while (sent_count - start < 35) begin
					if ($urandom_range(99) < 75) begin
						send_frame();
					end else begin
						// Noise, sometimes a lone first marker.
						if ($urandom_range(3) == 0)
							send_byte(sb.first_mark);
						repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
					end
				end
			end
			drain();
		end

		send_idle_pct = 0;
		stall_pct     = 0;
		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tagged_string_extractor test passed");
		end else begin
			$display("tagged_string_extractor test failed");
		end
		$finish;
	end

endmodule
